/* rtl/bmp24_pkg.sv */
package bmp24_pkg;

    // decoder phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DATA,
        PH_PAD,
        PH_TAIL,
        PH_DRAIN
    } phase_t;

    // status codes carried by a status request
    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT_HEADER,
        ST_SIGNATURE,
        ST_COMPRESSED,
        ST_DEPTH,
        ST_SIZE_SMALL,
        ST_SHORT_DATA,
        ST_GEOMETRY
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_ENABLE,
        REG_KEY_RED,
        REG_KEY_GREEN,
        REG_KEY_BLUE
    } reg_index_t;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // header layout
    localparam logic [5:0]  HEADER_LEN   = 6'd54;
    localparam logic [5:0]  OFS_OFFSET   = 6'h0A;
    localparam logic [5:0]  OFS_WIDTH    = 6'h12;
    localparam logic [5:0]  OFS_HEIGHT   = 6'h16;
    localparam logic [5:0]  OFS_DEPTH    = 6'h1C;
    localparam logic [5:0]  OFS_COMPRESS = 6'h1E;
    localparam logic [5:0]  OFS_SIZE     = 6'h22;
    localparam logic [7:0]  SIG_B        = 8'h42;
    localparam logic [7:0]  SIG_M        = 8'h4D;
    localparam logic [15:0] DEPTH_24     = 16'd24;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;

    // one result request
    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
        logic [2:0]  status;
    } result_t;

    function automatic result_t make_status(input status_t code);
        result_t r;
        r            = '0;
        r.kind       = KIND_STATUS;
        r.status     = code;
        return r;
    endfunction

endpackage

/* rtl/bmp24_stream_decoder.sv */
// Streaming decoder for uncompressed 24-bit BMP files. One file byte is taken
// per clock unless in_stall is high; each byte yields at most two result
// requests (a pixel and, on the end_of_file byte, a status), written into a
// four-entry result queue. A byte is taken in a cycle in which the queue has
// room for two requests, so with the output side never stalled the block
// sustains one byte per cycle; results are read from the registered queue. The
// header is checked on its 54th byte from geometry products precomputed in
// registers while the remaining header bytes arrive. Pixels leave in stored
// order, bottom row first, with alpha cleared when the key colour matches.
module bmp24_stream_decoder
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [11:0] column,
    output logic [11:0] row,
    output logic        last_pixel,
    output logic [2:0]  status,
    // configuration
    input  logic        write_enable,
    input  logic [1:0]  register_index,
    input  logic [7:0]  write_data
);

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int WH_W    = 2 * DIM_W;
    localparam int LEAST_W = WH_W + 2;
    localparam int LINE_W  = DIM_W + 2;
    localparam int LP_W    = DIM_W + LINE_W;
    localparam int SPAN_W  = LP_W + 1;
    localparam int NEED_W  = (SPAN_W > 32) ? SPAN_W : 32;
    localparam int POS_W   = NEED_W + 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // configuration registers
    logic        key_enable_reg;
    logic [7:0]  key_red_reg;
    logic [7:0]  key_green_reg;
    logic [7:0]  key_blue_reg;

    // per-file state
    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [31:0]         data_offset_reg, data_offset_next;
    logic [31:0]         image_bytes_reg, image_bytes_next;
    logic [31:0]         image_width_reg, image_width_next;
    logic [31:0]         image_height_reg, image_height_next;
    logic [31:0]         compression_reg, compression_next;
    logic [15:0]         depth_reg, depth_next;
    logic                sig_ok_reg, sig_ok_next;
    logic [DIM_W-1:0]    col_reg, col_next;
    logic [DIM_W-1:0]    row_reg, row_next;
    logic [1:0]          chan_reg, chan_next;
    logic [1:0]          pad_reg, pad_next;
    logic [7:0]          blue_hold_reg, blue_hold_next;
    logic [7:0]          green_hold_reg, green_hold_next;
    logic [POS_W-1:0]    data_end_reg, data_end_next;
    logic                need_zero_reg, need_zero_next;

    // geometry precompute
    logic [WH_W-1:0]     wh_reg;
    logic [LP_W-1:0]     lp_reg;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic                small_reg, small_next;

    // result queue
    result_t             q_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]     count_reg, count_next;

    logic                accept, pop;
    logic [5:0]          pos6;
    logic [POS_W-1:0]    pos_inc;
    logic [DIM_W-1:0]    w_dim, h_dim, h_m1, col_inc, row_inc;
    logic [LINE_W-1:0]   w3, line_bytes;
    logic [LEAST_W-1:0]  least;
    logic [SPAN_W-1:0]   span;
    logic [31:0]         size_eff, off_eff;
    logic                no_pixels, geom_bad, hdr_end, skip_go;
    logic                pix_fire, col_wrap, row_wrap, tail_next, data_done;
    logic                keyed;
    status_t             hdr_code, end_code;
    result_t             res_first, res_second, pixel_res;
    logic [1:0]          n_push;

    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;
    assign in_stall = count_reg > Q_CW'(Q_DEPTH - 2);

    assign pos6    = pos_reg[5:0];
    assign pos_inc = (&pos_reg) ? pos_reg : pos_reg + POS_W'(1);

    // geometry arithmetic
    assign w_dim      = image_width_reg[DIM_W-1:0];
    assign h_dim      = image_height_reg[DIM_W-1:0];
    assign h_m1       = h_dim - DIM_W'(1);
    assign w3         = LINE_W'(w_dim) + LINE_W'({w_dim, 1'b0});
    assign line_bytes = (w3 + LINE_W'(3)) & ~LINE_W'(3);
    assign least      = LEAST_W'({wh_reg, 1'b0}) + LEAST_W'(wh_reg);
    assign span       = (least == '0) ? '0 : SPAN_W'(lp_reg) + SPAN_W'(w3);
    assign size_eff   = (image_bytes_reg == '0) ? 32'(least) : image_bytes_reg;
    assign small_next = size_eff[31] || (NEED_W'(size_eff) < NEED_W'(least));
    assign need_next  = (NEED_W'(size_eff) > NEED_W'(span)) ? NEED_W'(size_eff)
                                                          : NEED_W'(span);

    // header check
    assign off_eff   = (data_offset_reg == '0) ? 32'(HEADER_LEN) : data_offset_reg;
    assign no_pixels = (image_width_reg == '0) || (image_height_reg == '0);
    assign geom_bad  = (image_width_reg > 32'(MAX_DIM)) || (image_height_reg > 32'(MAX_DIM))
                    || off_eff[31] || (off_eff < 32'(HEADER_LEN));
    assign hdr_end   = pos_reg == POS_W'(HEADER_LEN - 6'd1);

    always_comb
    begin
        if (!sig_ok_reg)
            hdr_code = ST_SIGNATURE;
        else if (compression_reg != '0)
            hdr_code = ST_COMPRESSED;
        else if (depth_reg != DEPTH_24)
            hdr_code = ST_DEPTH;
        else if (geom_bad)
            hdr_code = ST_GEOMETRY;
        else if (small_reg)
            hdr_code = ST_SIZE_SMALL;
        else
            hdr_code = ST_OK;
    end

    // pixel walk
    assign skip_go   = pos_inc >= POS_W'(data_offset_reg);
    assign pix_fire  = (phase_reg == PH_DATA) && (chan_reg == 2'd2);
    assign col_inc   = col_reg + DIM_W'(1);
    assign row_inc   = row_reg + DIM_W'(1);
    assign col_wrap  = col_inc == w_dim;
    assign row_wrap  = row_inc == h_dim;
    assign tail_next = (phase_reg == PH_TAIL) || (pix_fire && col_wrap && row_wrap);
    assign data_done = (tail_next || no_pixels) && (need_zero_reg || (pos_inc >= data_end_reg));
    assign keyed     = key_enable_reg && (file_byte == key_red_reg)
                    && (green_hold_reg == key_green_reg) && (blue_hold_reg == key_blue_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (end_of_file)
                phase_next = PH_HEADER;
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (hdr_end)
                        begin
                            if (hdr_code != ST_OK)
                                phase_next = PH_DRAIN;
                            else if (off_eff > 32'(HEADER_LEN))
                                phase_next = PH_SKIP;
                            else
                                phase_next = no_pixels ? PH_TAIL : PH_DATA;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_go)
                            phase_next = no_pixels ? PH_TAIL : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (pix_fire && col_wrap)
                        begin
                            if (row_wrap)
                                phase_next = PH_TAIL;
                            else if (w_dim[1:0] != 2'd0)
                                phase_next = PH_PAD;
                        end
                    end
                    PH_PAD:
                    begin
                        if (pad_reg <= 2'd1)
                            phase_next = PH_DATA;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // per-byte datapath
    always_comb
    begin
        pos_next          = pos_reg;
        data_offset_next  = data_offset_reg;
        image_bytes_next  = image_bytes_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        compression_next  = compression_reg;
        depth_next        = depth_reg;
        sig_ok_next       = sig_ok_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        chan_next         = chan_reg;
        pad_next          = pad_reg;
        blue_hold_next    = blue_hold_reg;
        green_hold_next   = green_hold_reg;
        data_end_next     = data_end_reg;
        need_zero_next    = need_zero_reg;
        if (accept)
        begin
            if (phase_reg != PH_DRAIN)
                pos_next = pos_inc;
            case (phase_reg)
                PH_HEADER:
                begin
                    // byte capture into header words
                    if (pos6 == 6'd0)
                        sig_ok_next = file_byte == SIG_B;
                    else if (pos6 == 6'd1)
                        sig_ok_next = sig_ok_reg && (file_byte == SIG_M);
                    else if (pos6 inside {[OFS_OFFSET:OFS_OFFSET + 6'd3]})
                        data_offset_next[8*(2'(pos6 - OFS_OFFSET)) +: 8] = file_byte;
                    else if (pos6 inside {[OFS_WIDTH:OFS_WIDTH + 6'd3]})
                        image_width_next[8*(2'(pos6 - OFS_WIDTH)) +: 8] = file_byte;
                    else if (pos6 inside {[OFS_HEIGHT:OFS_HEIGHT + 6'd3]})
                        image_height_next[8*(2'(pos6 - OFS_HEIGHT)) +: 8] = file_byte;
                    else if (pos6 inside {[OFS_DEPTH:OFS_DEPTH + 6'd1]})
                        depth_next[8*(1'(pos6 - OFS_DEPTH)) +: 8] = file_byte;
                    else if (pos6 inside {[OFS_COMPRESS:OFS_COMPRESS + 6'd3]})
                        compression_next[8*(2'(pos6 - OFS_COMPRESS)) +: 8] = file_byte;
                    else if (pos6 inside {[OFS_SIZE:OFS_SIZE + 6'd3]})
                        image_bytes_next[8*(2'(pos6 - OFS_SIZE)) +: 8] = file_byte;
                    // last header byte: fix offset and data demand
                    if (hdr_end)
                    begin
                        data_offset_next = off_eff;
                        data_end_next    = POS_W'(off_eff) + POS_W'(need_reg);
                        need_zero_next   = need_reg == '0;
                    end
                end
                PH_DATA:
                begin
                    case (chan_reg)
                        2'd0:
                        begin
                            blue_hold_next = file_byte;
                            chan_next      = 2'd1;
                        end
                        2'd1:
                        begin
                            green_hold_next = file_byte;
                            chan_next       = 2'd2;
                        end
                        default:
                        begin
                            chan_next = 2'd0;
                            if (col_wrap)
                            begin
                                col_next = '0;
                                row_next = row_inc;
                                pad_next = w_dim[1:0];
                            end
                            else
                                col_next = col_inc;
                        end
                    endcase
                end
                PH_PAD:
                begin
                    if (pad_reg != 2'd0)
                        pad_next = pad_reg - 2'd1;
                end
                default:
                begin
                    pos_next = pos_next;
                end
            endcase
            // end of file starts a new file
            if (end_of_file)
            begin
                pos_next          = '0;
                data_offset_next  = '0;
                image_bytes_next  = '0;
                image_width_next  = '0;
                image_height_next = '0;
                compression_next  = '0;
                depth_next        = '0;
                sig_ok_next       = 1'b0;
                col_next          = '0;
                row_next          = '0;
                chan_next         = '0;
                pad_next          = '0;
                data_end_next     = '0;
                need_zero_next    = 1'b0;
            end
        end
    end

    // result requests for this byte
    always_comb
    begin
        pixel_res            = '0;
        pixel_res.kind       = KIND_PIXEL;
        pixel_res.red        = file_byte;
        pixel_res.green      = green_hold_reg;
        pixel_res.blue       = blue_hold_reg;
        pixel_res.alpha      = keyed ? ALPHA_CLEAR : ALPHA_OPAQUE;
        pixel_res.column     = 12'(col_reg);
        pixel_res.row        = 12'(row_reg);
        pixel_res.last_pixel = col_wrap && row_wrap;
        pixel_res.status     = ST_OK;

        end_code   = data_done ? ST_OK : ST_SHORT_DATA;
        res_first  = make_status(end_code);
        res_second = make_status(end_code);
        n_push     = 2'd0;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (!hdr_end)
                    begin
                        if (end_of_file)
                        begin
                            res_first = make_status(ST_SHORT_HEADER);
                            n_push    = 2'd1;
                        end
                    end
                    else if (hdr_code != ST_OK)
                    begin
                        res_first = make_status(hdr_code);
                        n_push    = 2'd1;
                    end
                    else if (end_of_file)
                    begin
                        res_first = make_status((no_pixels && need_reg == '0)
                                                ? ST_OK : ST_SHORT_DATA);
                        n_push    = 2'd1;
                    end
                end
                PH_DRAIN:
                begin
                    n_push = 2'd0;
                end
                default:
                begin
                    if (pix_fire)
                    begin
                        res_first = pixel_res;
                        n_push    = end_of_file ? 2'd2 : 2'd1;
                    end
                    else if (end_of_file)
                        n_push = 2'd1;
                end
            endcase
        end
    end

    assign count_next = count_reg + Q_CW'(n_push) - Q_CW'(pop);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_enable_reg   <= 1'b0;
            key_red_reg      <= '0;
            key_green_reg    <= '0;
            key_blue_reg     <= '0;
            phase_reg        <= PH_HEADER;
            pos_reg          <= '0;
            data_offset_reg  <= '0;
            image_bytes_reg  <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            compression_reg  <= '0;
            depth_reg        <= '0;
            sig_ok_reg       <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            chan_reg         <= '0;
            pad_reg          <= '0;
            data_end_reg     <= '0;
            need_zero_reg    <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (write_enable)
            begin
                case (register_index)
                    REG_KEY_ENABLE: key_enable_reg <= write_data[0];
                    REG_KEY_RED:    key_red_reg    <= write_data;
                    REG_KEY_GREEN:  key_green_reg  <= write_data;
                    REG_KEY_BLUE:   key_blue_reg   <= write_data;
                    default:        key_enable_reg <= key_enable_reg;
                endcase
            end
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            data_offset_reg  <= data_offset_next;
            image_bytes_reg  <= image_bytes_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            compression_reg  <= compression_next;
            depth_reg        <= depth_next;
            sig_ok_reg       <= sig_ok_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            chan_reg         <= chan_next;
            pad_reg          <= pad_next;
            data_end_reg     <= data_end_next;
            need_zero_reg    <= need_zero_next;
            wr_ptr_reg       <= wr_ptr_reg + Q_AW'(n_push);
            rd_ptr_reg       <= rd_ptr_reg + Q_AW'(pop);
            count_reg        <= count_next;
        end
    end

    // payload registers: pixel holds, geometry pipeline, result queue
    always_ff @(posedge clk)
    begin
        blue_hold_reg  <= blue_hold_next;
        green_hold_reg <= green_hold_next;
        wh_reg         <= WH_W'(w_dim) * WH_W'(h_dim);
        lp_reg         <= LP_W'(h_m1) * LP_W'(line_bytes);
        need_reg       <= need_next;
        small_reg      <= small_next;
        if (n_push != 2'd0)
            q_reg[wr_ptr_reg] <= res_first;
        if (n_push == 2'd2)
            q_reg[wr_ptr_reg + Q_AW'(1)] <= res_second;
    end

    // output side
    assign out_valid  = count_reg != '0;
    assign kind       = q_reg[rd_ptr_reg].kind;
    assign red        = q_reg[rd_ptr_reg].red;
    assign green      = q_reg[rd_ptr_reg].green;
    assign blue       = q_reg[rd_ptr_reg].blue;
    assign alpha      = q_reg[rd_ptr_reg].alpha;
    assign column     = q_reg[rd_ptr_reg].column;
    assign row        = q_reg[rd_ptr_reg].row;
    assign last_pixel = q_reg[rd_ptr_reg].last_pixel;
    assign status     = q_reg[rd_ptr_reg].status;

endmodule

/* test/bmp24_stream_decoder_tb.sv */
module bmp24_stream_decoder_tb;
    import bmp24_pkg::*;

    localparam int HDR_LEN        = 54;
    localparam int MAX_DIM        = 4096;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 400000;

    // decoder predictor and store of predicted requests
    class bmp_scoreboard;
        result_t decoded_q[$];
        int      errors;

        // key colour as last written
        bit       key_on;
        logic [7:0] key_r, key_g, key_b;

        // per-file decoder state
        phase_t          ph;
        longint unsigned pos;
        logic [31:0]     offset_w, size_w, width_w, height_w, compress_w;
        logic [15:0]     depth_w;
        bit              sig_ok;
        int unsigned     col, rw, chan, pad;
        logic [7:0]      blue_h, green_h;
        longint unsigned need;

        function new();
            key_on = 1'b0;
            key_r  = 8'd0;
            key_g  = 8'd0;
            key_b  = 8'd0;
            errors = 0;
            restart_file();
        endfunction

        function void restart_file();
            ph         = PH_HEADER;
            pos        = 0;
            offset_w   = '0;
            size_w     = '0;
            width_w    = '0;
            height_w   = '0;
            compress_w = '0;
            depth_w    = '0;
            sig_ok     = 1'b0;
            col        = 0;
            rw         = 0;
            chan       = 0;
            pad        = 0;
            blue_h     = '0;
            green_h    = '0;
            need       = 0;
        endfunction

        function void push_status(status_t code);
            result_t r;
            r        = '0;
            r.kind   = KIND_STATUS;
            r.status = code;
            decoded_q.push_back(r);
        endfunction

        // little-endian header words gathered byte by byte
        function void capture_header_byte(int p, logic [7:0] b);
            if (p == 0)
                sig_ok = (b == SIG_B);
            else if (p == 1)
                sig_ok = sig_ok && (b == SIG_M);
            else if (p >= int'(OFS_OFFSET) && p < int'(OFS_OFFSET) + 4)
                offset_w[8 * (p - int'(OFS_OFFSET)) +: 8] = b;
            else if (p >= int'(OFS_WIDTH) && p < int'(OFS_WIDTH) + 4)
                width_w[8 * (p - int'(OFS_WIDTH)) +: 8] = b;
            else if (p >= int'(OFS_HEIGHT) && p < int'(OFS_HEIGHT) + 4)
                height_w[8 * (p - int'(OFS_HEIGHT)) +: 8] = b;
            else if (p >= int'(OFS_DEPTH) && p < int'(OFS_DEPTH) + 2)
                depth_w[8 * (p - int'(OFS_DEPTH)) +: 8] = b;
            else if (p >= int'(OFS_COMPRESS) && p < int'(OFS_COMPRESS) + 4)
                compress_w[8 * (p - int'(OFS_COMPRESS)) +: 8] = b;
            else if (p >= int'(OFS_SIZE) && p < int'(OFS_SIZE) + 4)
                size_w[8 * (p - int'(OFS_SIZE)) +: 8] = b;
        endfunction

        // header checks in order signature, compression, depth, geometry, size; defaults applied on the way
        function status_t vet_header();
            longint w, h, off, size, least, line, span;
            w = longint'($signed(width_w));
            h = longint'($signed(height_w));
            if (!sig_ok)
                return ST_SIGNATURE;
            if (compress_w != 0)
                return ST_COMPRESSED;
            if (depth_w != DEPTH_24)
                return ST_DEPTH;
            if (offset_w == 0)
                offset_w = HDR_LEN;
            off = longint'($signed(offset_w));
            if (w < 0 || w > MAX_DIM || h < 0 || h > MAX_DIM || off < HDR_LEN)
                return ST_GEOMETRY;
            least = w * h * 3;
            if (size_w == 0)
                size_w = least[31:0];
            size = longint'($signed(size_w));
            if (size < least)
                return ST_SIZE_SMALL;
            line = (w * 3 + 3) & ~longint'(3);
            span = (least == 0) ? 0 : (h - 1) * line + w * 3;
            need = (size > span) ? size : span;
            return ST_OK;
        endfunction

        function bit image_empty();
            return width_w == 0 || height_w == 0;
        endfunction

        function void begin_pixels();
            col  = 0;
            rw   = 0;
            chan = 0;
            pad  = 0;
            ph   = image_empty() ? PH_TAIL : PH_DATA;
        endfunction

        function bit data_done();
            if (!(ph == PH_TAIL || image_empty()))
                return 1'b0;
            return need == 0 || pos >= {32'd0, offset_w} + need;
        endfunction

        // one accepted byte request: predict what it yields
        function void note_byte(logic [7:0] b, logic eof);
            result_t         r;
            longint unsigned at;
            status_t         st;
            bit              keyed, fin;
            if (ph == PH_DRAIN)
            begin
                if (eof)
                    restart_file();
                return;
            end
            at  = pos;
            pos = pos + 1;
            case (ph)
                PH_HEADER:
                begin
                    capture_header_byte(int'(at), b);
                    if (pos < HDR_LEN)
                    begin
                        if (eof)
                        begin
                            push_status(ST_SHORT_HEADER);
                            restart_file();
                        end
                        return;
                    end
                    st = vet_header();
                    if (st != ST_OK)
                    begin
                        push_status(st);
                        if (eof)
                            restart_file();
                        else
                            ph = PH_DRAIN;
                        return;
                    end
                    if ($signed(offset_w) > HDR_LEN)
                        ph = PH_SKIP;
                    else
                        begin_pixels();
                end
                PH_SKIP:
                begin
                    if (pos >= {32'd0, offset_w})
                        begin_pixels();
                end
                PH_DATA:
                begin
                    if (chan == 0)
                    begin
                        blue_h = b;
                        chan   = 1;
                    end
                    else if (chan == 1)
                    begin
                        green_h = b;
                        chan    = 2;
                    end
                    else
                    begin
                        keyed = key_on && b == key_r && green_h == key_g && blue_h == key_b;
                        fin   = (rw + 1 == height_w) && (col + 1 == width_w);
                        r            = '0;
                        r.kind       = KIND_PIXEL;
                        r.red        = b;
                        r.green      = green_h;
                        r.blue       = blue_h;
                        r.alpha      = keyed ? ALPHA_CLEAR : ALPHA_OPAQUE;
                        r.column     = col[11:0];
                        r.row        = rw[11:0];
                        r.last_pixel = fin;
                        r.status     = ST_OK;
                        decoded_q.push_back(r);
                        chan = 0;
                        col  = col + 1;
                        if (col >= width_w)
                        begin
                            col = 0;
                            rw  = rw + 1;
                            if (rw >= height_w)
                                ph = PH_TAIL;
                            else
                            begin
                                pad = (4 - (int'(width_w[1:0]) * 3) % 4) % 4;
                                if (pad != 0)
                                    ph = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD:
                begin
                    if (pad > 0)
                        pad = pad - 1;
                    if (pad == 0)
                        ph = PH_DATA;
                end
                default:
                begin
                end
            endcase
            if (eof)
            begin
                push_status(data_done() ? ST_OK : ST_SHORT_DATA);
                restart_file();
            end
        endfunction

        function void compare_field(string field, logic [11:0] want, logic [11:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d actual %0d", field, want, got);
                errors++;
            end
        endfunction

        // one accepted result request against the oldest prediction
        function void check_result(result_t got);
            result_t want;
            if (decoded_q.size() == 0)
            begin
                $error("result request with nothing predicted: kind %0d status %0d",
                       got.kind, got.status);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            compare_field("kind", 12'(want.kind), 12'(got.kind));
            compare_field("red", 12'(want.red), 12'(got.red));
            compare_field("green", 12'(want.green), 12'(got.green));
            compare_field("blue", 12'(want.blue), 12'(got.blue));
            compare_field("alpha", 12'(want.alpha), 12'(got.alpha));
            compare_field("column", want.column, got.column);
            compare_field("row", want.row, got.row);
            compare_field("last_pixel", 12'(want.last_pixel), 12'(got.last_pixel));
            compare_field("status", 12'(want.status), 12'(got.status));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  file_byte = 8'd0;
    logic        end_of_file = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [7:0]  red, green, blue, alpha;
    logic [11:0] column, row;
    logic        last_pixel;
    logic [2:0]  status;
    logic        write_enable = 1'b0;
    reg_index_t  register_index = REG_KEY_ENABLE;
    logic [7:0]  write_data = 8'd0;

    bmp_scoreboard sb = new();
    logic [7:0]    file_q[$];
    int            send_idle_pct = 0;
    int            out_stall_pct = 0;
    int            bytes_sent = 0;

    bmp24_stream_decoder #(.MAX_DIM(MAX_DIM)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .file_byte      (file_byte),
        .end_of_file    (end_of_file),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .column         (column),
        .row            (row),
        .last_pixel     (last_pixel),
        .status         (status),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data)
    );

    always #6 clk = ~clk;

    // random back-pressure on the result side
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    // byte requests are predicted before results are checked in the same edge
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_byte(file_byte, end_of_file);
        if (out_valid && !out_stall)
            sb.check_result(result_t'({kind, red, green, blue, alpha, column, row,
                                       last_pixel, status}));
    end

    // hard stop for a hung run
    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        file_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // register writes leave write_enable high until the caller drops it
    task automatic write_register(input reg_index_t idx, input logic [7:0] data);
        write_enable   <= 1'b1;
        register_index <= idx;
        write_data     <= data;
        @(posedge clk);
        case (idx)
            REG_KEY_ENABLE: sb.key_on = data[0];
            REG_KEY_RED:    sb.key_r  = data;
            REG_KEY_GREEN:  sb.key_g  = data;
            REG_KEY_BLUE:   sb.key_b  = data;
            default:        ;
        endcase
    endtask

    task automatic set_key(input bit on, input logic [7:0] r, g, b);
        write_register(REG_KEY_ENABLE, {7'd0, on});
        write_register(REG_KEY_RED, r);
        write_register(REG_KEY_GREEN, g);
        write_register(REG_KEY_BLUE, b);
        write_enable <= 1'b0;
    endtask

    // sender holds off until every predicted request has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_word(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(v[8 * i +: 8]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) file_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_header(input bit bad_sig, input logic [31:0] off, w, h,
                              input logic [15:0] depth, input logic [31:0] comp, size);
        logic [7:0] s0, s1;
        s0 = SIG_B;
        s1 = SIG_M;
        if (bad_sig)
        begin
            s0 = 8'($urandom_range(255));
            s1 = 8'($urandom_range(255));
            if (s0 == SIG_B && s1 == SIG_M)
                s1 = ~SIG_M;
        end
        file_q.push_back(s0);
        file_q.push_back(s1);
        // file size and reserved words are ignored
        add_word($urandom, 4);
        add_word($urandom, 4);
        add_word(off, 4);
        add_word($urandom, 4);
        add_word(w, 4);
        add_word(h, 4);
        add_word($urandom, 2);
        add_word({16'd0, depth}, 2);
        add_word(comp, 4);
        add_word(size, 4);
        add_noise(HDR_LEN - 38);
    endtask

    // stored BGR triple, often the key colour
    task automatic add_pixel(input bit force_key);
        if (force_key || $urandom_range(2) == 0)
        begin
            file_q.push_back(sb.key_b);
            file_q.push_back(sb.key_g);
            file_q.push_back(sb.key_r);
        end
        else
            add_noise(3);
    endtask

    task automatic add_body(input int w, h, gap);
        int pad_n;
        pad_n = (4 - (w * 3) % 4) % 4;
        add_noise(gap);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
                add_pixel(1'b0);
            add_noise(pad_n);
        end
    endtask

    // send the built file, possibly cut short, end of file on its final byte
    task automatic send_file(input int keep = 1 << 30);
        int n;
        n = (keep < file_q.size()) ? keep : file_q.size();
        for (int i = 0; i < n; i++)
            push_byte(file_q[i], i == n - 1);
        file_q.delete();
    endtask

    task automatic directed_files();
        // lone byte carrying end of file
        file_q.push_back(8'h00);
        send_file();
        // header one byte short
        repeat (HDR_LEN - 1) file_q.push_back(8'hFF);
        send_file();
        // single keyed pixel, offset and size left to their defaults
        add_header(1'b0, 0, 1, 1, DEPTH_24, 0, 0);
        add_pixel(1'b1);
        send_file();
        // two rows with padding behind a gap before the data
        add_header(1'b0, HDR_LEN + 6, 2, 2, DEPTH_24, 0, 0);
        add_body(2, 2, 6);
        send_file();
        // each header check failing in turn
        add_header(1'b1, 0, 1, 1, DEPTH_24, 0, 0);
        add_noise(3);
        send_file();
        add_header(1'b0, 0, 1, 1, DEPTH_24, 1, 0);
        send_file();
        add_header(1'b0, 0, 1, 1, 16'd32, 0, 0);
        add_noise(2);
        send_file();
        add_header(1'b0, 0, MAX_DIM + 1, 1, DEPTH_24, 0, 0);
        send_file();
        add_header(1'b0, 0, 1, 32'hFFFF_FFFF, DEPTH_24, 0, 0);
        send_file();
        add_header(1'b0, HDR_LEN - 1, 1, 1, DEPTH_24, 0, 0);
        send_file();
        add_header(1'b0, 0, 2, 1, DEPTH_24, 0, 5);
        add_noise(6);
        send_file();
        // data cut short
        add_header(1'b0, 0, 2, 2, DEPTH_24, 0, 0);
        add_body(2, 2, 0);
        send_file(HDR_LEN + 5);
        // empty images at the largest size
        add_header(1'b0, 0, MAX_DIM, 0, DEPTH_24, 0, 0);
        send_file();
        add_header(1'b0, 0, 0, MAX_DIM, DEPTH_24, 0, 0);
        add_noise(2);
        send_file();
        // largest image, cut after three pixels
        add_header(1'b0, 0, MAX_DIM, MAX_DIM, DEPTH_24, 0, 0);
        add_noise(9);
        send_file();
    endtask

    task automatic random_file();
        int          pick, w, h, gap, keep, n;
        logic [31:0] hw, hh, hoff, hcomp, hsize;
        logic [15:0] hdepth;
        bit          bad_sig, body;
        pick = $urandom_range(99);
        // mostly small images, a few wider and some empty
        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        if ($urandom_range(7) == 0)
            w = $urandom_range(7, 16);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 9);
        hw = w;
        hh = h;
        hoff = (gap == 0 && $urandom_range(1) == 0) ? 32'd0 : HDR_LEN + gap;
        case ($urandom_range(3))
            0:       hsize = 0;
            1:       hsize = w * h * 3;
            2:       hsize = w * h * 3 + $urandom_range(1, 12);
            default: hsize = h * ((w * 3 + 3) / 4 * 4);
        endcase
        hdepth  = DEPTH_24;
        hcomp   = 0;
        bad_sig = 1'b0;
        body    = 1'b0;
        keep    = 1 << 30;
        if (pick < 70)
            body = 1'b1;
        else if (pick < 76)
            bad_sig = 1'b1;
        else if (pick < 81)
            hcomp = 32'd1 << $urandom_range(31);
        else if (pick < 86)
        begin
            hdepth = 16'($urandom_range(65535));
            if (hdepth == DEPTH_24)
                hdepth = ~DEPTH_24;
        end
        else if (pick < 93)
        begin
            case ($urandom_range(4))
                0:       hw = 32'h8000_0000 | $urandom;
                1:       hw = MAX_DIM + $urandom_range(1, 3);
                2:       hh = 32'h8000_0000 | $urandom;
                3:       hh = MAX_DIM + $urandom_range(1, 1000);
                default: hoff = ($urandom_range(1) == 0) ? $urandom_range(1, HDR_LEN - 1)
                                                         : (32'h8000_0000 | $urandom);
            endcase
        end
        else if (pick < 96)
            hsize = (w * h > 0) ? $urandom_range(1, w * h * 3 - 1) : (32'h8000_0000 | $urandom);
        else if (pick < 98)
        begin
            // header cut short
            add_noise($urandom_range(1, HDR_LEN - 1));
            send_file();
            return;
        end
        else
        begin
            // loose bytes with scattered end of file marks, closed by one
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(255)), i == n - 1 || $urandom_range(15) == 0);
            return;
        end
        add_header(bad_sig, hoff, hw, hh, hdepth, hcomp, hsize);
        if (body)
        begin
            add_body(w, h, gap);
            add_noise($urandom_range(4));
            if ($urandom_range(9) == 0)
                keep = $urandom_range(HDR_LEN, file_q.size());
        end
        else
            add_noise($urandom_range(12));
        send_file(keep);
    endtask

    task automatic run_random(input int idle_pct, stall_pct, n_bytes);
        int start;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            random_file();
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed files with the key at its lowest colour, sender light
        set_key(1'b1, 8'h00, 8'h00, 8'h00);
        send_idle_pct = 25;
        out_stall_pct = 58;
        directed_files();
        drain_results();

        // sender light, receiver heavy
        set_key(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
        run_random(25, 58, 180);

        // sender heavy, receiver light, key at its highest colour
        set_key(1'b1, 8'hFF, 8'hFF, 8'hFF);
        run_random(58, 25, 180);

        // no idling, key disabled
        set_key(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
        run_random(0, 0, 180);

        if (sb.errors == 0 && sb.decoded_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
